// ----- hdl/ivq_pkg.sv -----
// Package for the virtual interrupt delivery queue.
// Holds the event and fault codes, shared constants and the structs between modules.
// No dependencies.
package ivq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam logic [7:0] NMI_VECTOR = 8'd2;

  typedef enum logic [2:0] {
    OP_EXT_IRQ    = 3'd0,
    OP_IRQ_WINDOW = 3'd1,
    OP_NMI        = 3'd2,
    OP_NMI_WINDOW = 3'd3,
    OP_PRIO_WRITE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_GP       = 2'd1,
    FAULT_OVERFLOW = 2'd2,
    FAULT_BAD_NMI  = 2'd3
  } fault_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] vector;
    logic       info_valid;
    logic       if_flag;
    logic       sti_shadow;
    logic       movss_shadow;
    logic       nmi_blocked;
    logic [7:0] priority_value;
  } item_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } ring_ctl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic       one_left;
    logic [7:0] head_vec;
  } ring_sts_t;

  typedef struct packed {
    logic       inject_valid;
    logic [7:0] inject_vector;
    logic       inject_nmi;
    logic       irq_window_request;
    logic       nmi_window_request;
    fault_e     fault_code;
    logic       halted;
  } result_t;

endpackage

// ----- hdl/ivq_ring.sv -----
// Pending vector ring: storage, head and tail pointers and fill count.
// Presents the head vector from a read port registered on the next head pointer, so it follows each pointer update.
// Depends on ivq_pkg.
module ivq_ring import ivq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ring_ctl_t ctl_i,
  output ring_sts_t sts_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    mem [QUEUE_DEPTH];
  logic [7:0]    rd_q, byp_data_q;
  logic          byp_q;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] ptr);
    return (ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr + PW'(1);
  endfunction

  always_comb begin
    head_d  = ctl_i.pop ? ptr_inc(head_q) : head_q;
    tail_d  = ctl_i.push ? ptr_inc(tail_q) : tail_q;
    count_d = count_q;
    if (ctl_i.push) begin
      count_d = count_q + CW'(1);
    end else if (ctl_i.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      byp_q   <= ctl_i.push && (tail_q == head_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= ctl_i.wdata;
    end
    rd_q       <= mem[head_d];
    byp_data_q <= ctl_i.wdata;
  end

  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == CW'(QUEUE_DEPTH));
  assign sts_o.one_left = (count_q == CW'(1));
  assign sts_o.head_vec = byp_q ? byp_data_q : rd_q;

endmodule

// ----- hdl/ivq_core.sv -----
// Event decision logic and guest interrupt state: NMI count, priority, window bits
// and the sticky terminal flag. Drives the ring and forms each result.
// Depends on ivq_pkg.
module ivq_core import ivq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  item_t     item_i,
  input  ring_sts_t ring_i,
  output ring_ctl_t ring_o,
  output result_t   res_o,
  output logic      term_o
);

  logic [7:0] nmi_cnt_q, nmi_cnt_d;
  logic [3:0] prio_q, prio_d;
  logic       irq_win_q, irq_win_d;
  logic       nmi_win_q, nmi_win_d;
  logic       term_q, term_d;
  logic       open_new, open_head;

  assign open_new  = item_i.if_flag && !item_i.sti_shadow && !item_i.movss_shadow &&
                     (item_i.vector[7:4] > prio_q);
  assign open_head = item_i.if_flag && !item_i.sti_shadow && !item_i.movss_shadow &&
                     (ring_i.head_vec[7:4] > prio_q);

  always_comb begin
    nmi_cnt_d           = nmi_cnt_q;
    prio_d              = prio_q;
    irq_win_d           = irq_win_q;
    nmi_win_d           = nmi_win_q;
    term_d              = term_q;
    ring_o.push         = 1'b0;
    ring_o.pop          = 1'b0;
    ring_o.wdata        = item_i.vector;
    res_o.inject_valid  = 1'b0;
    res_o.inject_vector = '0;
    res_o.inject_nmi    = 1'b0;
    res_o.fault_code    = FAULT_NONE;
    if (valid_i && !term_q) begin
      case (op_e'(item_i.opcode))
        OP_EXT_IRQ: begin
          if (item_i.info_valid) begin
            if (ring_i.empty && open_new) begin
              res_o.inject_valid  = 1'b1;
              res_o.inject_vector = item_i.vector;
            end else if (ring_i.full) begin
              term_d           = 1'b1;
              res_o.fault_code = FAULT_OVERFLOW;
            end else begin
              ring_o.push = 1'b1;
              irq_win_d   = 1'b1;
            end
          end
        end
        OP_IRQ_WINDOW: begin
          if (ring_i.empty) begin
            irq_win_d = 1'b0;
          end else if (open_head) begin
            ring_o.pop          = 1'b1;
            res_o.inject_valid  = 1'b1;
            res_o.inject_vector = ring_i.head_vec;
          end
        end
        OP_NMI: begin
          if (!item_i.info_valid) begin
            term_d           = 1'b1;
            res_o.fault_code = FAULT_BAD_NMI;
          end else if (item_i.nmi_blocked) begin
            if (nmi_cnt_q != 8'hff) begin
              nmi_cnt_d = nmi_cnt_q + 8'd1;
            end
            nmi_win_d = 1'b1;
          end else begin
            res_o.inject_valid  = 1'b1;
            res_o.inject_vector = NMI_VECTOR;
            res_o.inject_nmi    = 1'b1;
          end
        end
        OP_NMI_WINDOW: begin
          if (nmi_cnt_q == '0) begin
            nmi_win_d = 1'b0;
          end else begin
            nmi_cnt_d           = nmi_cnt_q - 8'd1;
            res_o.inject_valid  = 1'b1;
            res_o.inject_vector = NMI_VECTOR;
            res_o.inject_nmi    = 1'b1;
            if (nmi_cnt_q == 8'd1) begin
              nmi_win_d = 1'b0;
            end
          end
        end
        OP_PRIO_WRITE: begin
          if (item_i.priority_value[7:4] != '0) begin
            res_o.fault_code = FAULT_GP;
          end else begin
            prio_d = item_i.priority_value[3:0];
          end
        end
        default: begin
        end
      endcase
    end
    // last entry leaves the ring
    if (ring_o.pop && ring_i.one_left) begin
      irq_win_d = 1'b0;
    end
    res_o.irq_window_request = irq_win_d;
    res_o.nmi_window_request = nmi_win_d;
    res_o.halted             = term_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nmi_cnt_q <= '0;
      prio_q    <= '0;
      irq_win_q <= 1'b0;
      nmi_win_q <= 1'b0;
      term_q    <= 1'b0;
    end else begin
      nmi_cnt_q <= nmi_cnt_d;
      prio_q    <= prio_d;
      irq_win_q <= irq_win_d;
      nmi_win_q <= nmi_win_d;
      term_q    <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

// ----- hdl/virtual_interrupt_delivery_queue.sv -----
// Top level of the virtual interrupt delivery queue: request register, result register,
// ring and event logic. Depends on ivq_pkg, ivq_ring and ivq_core.
//
//   channel  | handshake              | payload
//   request  | start, busy            | opcode_i .. priority_value_i
//   result   | done_o (one cycle)     | inject_valid_o .. halted_o
//
// One request is taken every cycle; busy stays low.
// The event logic works on the request register during the cycle after the request is
// taken and loads the result register at the next edge, so done_o rises together with
// the new result, which is accepted while done_o is high.
// The ring head is read from a registered memory port fed by the next head pointer.
// Reset clears pointers, counters, flags and the pipeline valids; ring contents are not cleared.
// Results cannot be held off, so nothing in the pipeline waits on the receiver.
module virtual_interrupt_delivery_queue import ivq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] opcode_i,
  input  logic [7:0] vector_i,
  input  logic       info_valid_i,
  input  logic       if_flag_i,
  input  logic       sti_shadow_i,
  input  logic       movss_shadow_i,
  input  logic       nmi_blocked_i,
  input  logic [7:0] priority_value_i,
  output logic       done_o,
  output logic       inject_valid_o,
  output logic [7:0] inject_vector_o,
  output logic       inject_nmi_o,
  output logic       irq_window_request_o,
  output logic       nmi_window_request_o,
  output logic [1:0] fault_code_o,
  output logic       halted_o
);

  item_t     in_q;
  logic      in_valid_q;
  result_t   res_d, res_q;
  logic      done_q;
  ring_ctl_t ring_ctl;
  ring_sts_t ring_sts;
  logic      term;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
      done_q     <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      in_q.opcode         <= opcode_i;
      in_q.vector         <= vector_i;
      in_q.info_valid     <= info_valid_i;
      in_q.if_flag        <= if_flag_i;
      in_q.sti_shadow     <= sti_shadow_i;
      in_q.movss_shadow   <= movss_shadow_i;
      in_q.nmi_blocked    <= nmi_blocked_i;
      in_q.priority_value <= priority_value_i;
    end
    if (in_valid_q) begin
      res_q <= res_d;
    end
  end

  ivq_ring #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ring (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ring_ctl),
    .sts_o (ring_sts)
  );

  ivq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(in_valid_q),
    .item_i (in_q),
    .ring_i (ring_sts),
    .ring_o (ring_ctl),
    .res_o  (res_d),
    .term_o (term)
  );

  assign done_o               = done_q;
  assign inject_valid_o       = res_q.inject_valid;
  assign inject_vector_o      = res_q.inject_vector;
  assign inject_nmi_o         = res_q.inject_nmi;
  assign irq_window_request_o = res_q.irq_window_request;
  assign nmi_window_request_o = res_q.nmi_window_request;
  assign fault_code_o         = res_q.fault_code;
  assign halted_o             = res_q.halted;

  a_term_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term |=> term)
    else $error("terminal flag cleared without reset");

  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_ctl.push && ring_ctl.pop))
    else $error("ring push and pop in one cycle");

  a_inject_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && inject_valid_o |-> fault_code_o == FAULT_NONE)
    else $error("injection reported together with a fault");

  a_nmi_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && inject_nmi_o |-> inject_valid_o && inject_vector_o == NMI_VECTOR)
    else $error("NMI injection with wrong vector");

endmodule

// ----- bench/virtual_interrupt_delivery_queue_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for virtual_interrupt_delivery_queue: directed and random event requests,
// each result checked against an in-bench prediction of the delivery queue.
// Depends on ivq_pkg and the virtual_interrupt_delivery_queue RTL.
module virtual_interrupt_delivery_queue_test;
  import ivq_pkg::*;

  localparam int unsigned DEPTH       = QUEUE_DEPTH_DEF;
  localparam int          ITEMS       = 1900;
  localparam int          QUIET_TAIL  = 300;
  localparam int          STALL_LIMIT = 500;
  localparam int          DRAIN_WAIT  = 8;

  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int MODE_FILL     = 0;
  localparam int MODE_DRAIN    = 1;
  localparam int MODE_NMI      = 2;
  localparam int MODE_NMI_WIN  = 3;
  localparam int MODE_PRIO     = 4;
  localparam int MODE_NOISE    = 5;
  localparam int MODE_SATURATE = 6;

  class injection_tracker;
    logic [7:0]  ring [DEPTH];
    int unsigned head, tail, count;
    logic [7:0]  nmi_count;
    logic [3:0]  level;
    bit          irq_win, nmi_win, halted;
    result_t     due_results [$];
    int          errors;

    function new();
      head = 0; tail = 0; count = 0; nmi_count = '0; level = '0;
      irq_win = 0; nmi_win = 0; halted = 0; errors = 0;
    endfunction

    function bit guest_takes(logic [7:0] vec, item_t it);
      return it.if_flag && !it.sti_shadow && !it.movss_shadow && (vec[7:4] > level);
    endfunction

    function void note_request(item_t it);
      result_t r;
      r = '0;
      r.fault_code = FAULT_NONE;
      if (!halted) begin
        case (it.opcode)
          OP_EXT_IRQ: begin
            if (it.info_valid) begin
              if (count == 0 && guest_takes(it.vector, it)) begin
                r.inject_valid  = 1'b1;
                r.inject_vector = it.vector;
              end else if (count >= DEPTH) begin
                halted       = 1;
                r.fault_code = FAULT_OVERFLOW;
              end else begin
                ring[tail] = it.vector;
                tail       = (tail + 1) % DEPTH;
                count++;
                irq_win = 1;
              end
            end
          end
          OP_IRQ_WINDOW: begin
            if (count == 0) begin
              irq_win = 0;
            end else if (guest_takes(ring[head], it)) begin
              r.inject_valid  = 1'b1;
              r.inject_vector = ring[head];
              head            = (head + 1) % DEPTH;
              count--;
              if (count == 0) irq_win = 0;
            end
          end
          OP_NMI: begin
            if (!it.info_valid) begin
              halted       = 1;
              r.fault_code = FAULT_BAD_NMI;
            end else if (it.nmi_blocked) begin
              if (nmi_count != 8'hFF) nmi_count++;
              nmi_win = 1;
            end else begin
              r.inject_valid  = 1'b1;
              r.inject_vector = NMI_VECTOR;
              r.inject_nmi    = 1'b1;
            end
          end
          OP_NMI_WINDOW: begin
            if (nmi_count == 0) begin
              nmi_win = 0;
            end else begin
              nmi_count--;
              r.inject_valid  = 1'b1;
              r.inject_vector = NMI_VECTOR;
              r.inject_nmi    = 1'b1;
              if (nmi_count == 0) nmi_win = 0;
            end
          end
          OP_PRIO_WRITE: begin
            if (it.priority_value > 8'd15) r.fault_code = FAULT_GP;
            else level = it.priority_value[3:0];
          end
          default: ;
        endcase
      end
      r.irq_window_request = irq_win;
      r.nmi_window_request = nmi_win;
      r.halted             = halted;
      due_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with no request outstanding, actual %0h", $time, got);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("inject_valid", want.inject_valid, got.inject_valid);
      compare_field("inject_vector", want.inject_vector, got.inject_vector);
      compare_field("inject_nmi", want.inject_nmi, got.inject_nmi);
      compare_field("irq_window_request", want.irq_window_request, got.irq_window_request);
      compare_field("nmi_window_request", want.nmi_window_request, got.nmi_window_request);
      compare_field("fault_code", want.fault_code, got.fault_code);
      compare_field("halted", want.halted, got.halted);
    endfunction
  endclass

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       start            = 1'b0;
  logic       busy;
  logic [2:0] opcode_i         = '0;
  logic [7:0] vector_i         = '0;
  logic       info_valid_i     = 1'b0;
  logic       if_flag_i        = 1'b0;
  logic       sti_shadow_i     = 1'b0;
  logic       movss_shadow_i   = 1'b0;
  logic       nmi_blocked_i    = 1'b0;
  logic [7:0] priority_value_i = '0;
  logic       done_o;
  logic       inject_valid_o;
  logic [7:0] inject_vector_o;
  logic       inject_nmi_o;
  logic       irq_window_request_o;
  logic       nmi_window_request_o;
  logic [1:0] fault_code_o;
  logic       halted_o;

  injection_tracker sb = new();
  int               stall_cycles;

  virtual_interrupt_delivery_queue u_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .opcode_i,
    .vector_i,
    .info_valid_i,
    .if_flag_i,
    .sti_shadow_i,
    .movss_shadow_i,
    .nmi_blocked_i,
    .priority_value_i,
    .done_o,
    .inject_valid_o,
    .inject_vector_o,
    .inject_nmi_o,
    .irq_window_request_o,
    .nmi_window_request_o,
    .fault_code_o,
    .halted_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && done_o) begin
      got.inject_valid       = inject_valid_o;
      got.inject_vector      = inject_vector_o;
      got.inject_nmi         = inject_nmi_o;
      got.irq_window_request = irq_window_request_o;
      got.nmi_window_request = nmi_window_request_o;
      got.fault_code         = fault_e'(fault_code_o);
      got.halted             = halted_o;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_request(input item_t it);
    start            <= 1'b1;
    opcode_i         <= it.opcode;
    vector_i         <= it.vector;
    info_valid_i     <= it.info_valid;
    if_flag_i        <= it.if_flag;
    sti_shadow_i     <= it.sti_shadow;
    movss_shadow_i   <= it.movss_shadow;
    nmi_blocked_i    <= it.nmi_blocked;
    priority_value_i <= it.priority_value;
    do @(posedge clk_i); while (busy);
    sb.note_request(it);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic item_t req(logic [2:0] op, logic [7:0] vec, bit valid, bit ifl, bit sti,
                                bit mss, bit nmib, logic [7:0] prio);
    item_t it;
    it.opcode         = op;
    it.vector         = vec;
    it.info_valid     = valid;
    it.if_flag        = ifl;
    it.sti_shadow     = sti;
    it.movss_shadow   = mss;
    it.nmi_blocked    = nmib;
    it.priority_value = prio;
    return it;
  endfunction

  function automatic item_t make_request(int mode);
    item_t      it;
    logic [23:0] raw;
    logic [3:0] head_class;
    raw = 24'($urandom);
    it  = raw;
    case (mode)
      MODE_FILL: begin
        it.opcode     = OP_EXT_IRQ;
        it.info_valid = 1'b1;
        if ($urandom_range(0, 3) != 0) it.if_flag = 1'b0;
      end
      MODE_DRAIN: begin
        it.opcode = OP_IRQ_WINDOW;
        if ($urandom_range(0, 7) != 0) begin
          it.if_flag      = 1'b1;
          it.sti_shadow   = 1'b0;
          it.movss_shadow = 1'b0;
        end
        if (sb.count != 0) begin
          head_class = sb.ring[sb.head][7:4];
          if (head_class != 0 && head_class <= sb.level) begin
            it.opcode         = OP_PRIO_WRITE;
            it.priority_value = $urandom_range(0, head_class - 1);
          end
        end
      end
      MODE_NMI: begin
        it.opcode     = OP_NMI;
        it.info_valid = 1'b1;
        if ($urandom_range(0, 3) != 0) it.nmi_blocked = 1'b1;
      end
      MODE_SATURATE: begin
        it.opcode      = OP_NMI;
        it.info_valid  = 1'b1;
        it.nmi_blocked = 1'b1;
      end
      MODE_NMI_WIN: it.opcode = OP_NMI_WINDOW;
      MODE_PRIO: begin
        it.opcode = OP_PRIO_WRITE;
        if ($urandom_range(0, 7) != 0) it.priority_value = $urandom_range(0, 15);
      end
      default: ;
    endcase
    // keep the block out of its terminal state and never queue a vector it can never deliver
    if (it.opcode == OP_EXT_IRQ && it.info_valid && (sb.count >= DEPTH || it.vector[7:4] == 0))
      it.info_valid = 1'b0;
    if (it.opcode == OP_NMI) it.info_valid = 1'b1;
    return it;
  endfunction

  initial begin
    int    counted;
    int    burst;
    int    mode;
    int    sat_at;
    bit    sat_done;
    bit    quiet;
    item_t it;

    counted  = 0;
    sat_done = 0;
    sat_at   = $urandom_range(200, 1400);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(req(OP_PRIO_WRITE, 8'h00, 1, 0, 0, 0, 0, 8'hFF));
    send_request(req(OP_PRIO_WRITE, 8'h00, 0, 0, 0, 0, 0, 8'h10));
    send_request(req(OP_PRIO_WRITE, 8'h00, 0, 0, 0, 0, 0, 8'h0F));
    send_request(req(OP_EXT_IRQ, 8'hFF, 1, 1, 0, 0, 0, 8'h00));
    send_request(req(OP_IRQ_WINDOW, 8'h00, 0, 1, 0, 0, 0, 8'h00));
    send_request(req(OP_PRIO_WRITE, 8'h00, 0, 0, 0, 0, 0, 8'h00));
    send_request(req(OP_IRQ_WINDOW, 8'h00, 0, 1, 1, 0, 0, 8'h00));
    send_request(req(OP_IRQ_WINDOW, 8'h00, 0, 1, 0, 1, 0, 8'h00));
    send_request(req(OP_IRQ_WINDOW, 8'h00, 0, 0, 0, 0, 0, 8'h00));
    send_request(req(OP_IRQ_WINDOW, 8'h00, 1, 1, 0, 0, 1, 8'hFF));
    send_request(req(OP_IRQ_WINDOW, 8'h00, 0, 1, 0, 0, 0, 8'h00));
    send_request(req(OP_EXT_IRQ, 8'h00, 0, 1, 0, 0, 0, 8'h00));
    send_request(req(OP_EXT_IRQ, 8'h10, 1, 1, 0, 0, 0, 8'h00));
    send_request(req(OP_NMI, 8'h00, 1, 0, 0, 0, 0, 8'h00));
    send_request(req(OP_NMI, 8'h00, 1, 0, 0, 0, 1, 8'h00));
    send_request(req(OP_NMI, 8'hFF, 1, 1, 1, 1, 1, 8'hFF));
    send_request(req(OP_NMI_WINDOW, 8'h00, 0, 0, 0, 0, 0, 8'h00));
    send_request(req(OP_NMI_WINDOW, 8'h00, 0, 0, 0, 0, 0, 8'h00));
    send_request(req(OP_NMI_WINDOW, 8'h00, 0, 0, 0, 0, 0, 8'h00));
    send_request(req(OP_SPARE_5, 8'hFF, 1, 1, 1, 1, 1, 8'hFF));
    send_request(req(OP_SPARE_6, 8'h00, 0, 0, 0, 0, 0, 8'h00));
    send_request(req(OP_SPARE_7, 8'hAA, 1, 0, 1, 0, 1, 8'h55));

    while (counted < ITEMS) begin
      if (!sat_done && counted >= sat_at) begin
        mode     = MODE_SATURATE;
        burst    = 270;
        sat_done = 1;
      end else begin
        case ($urandom_range(0, 10))
          0, 1, 2: mode = MODE_FILL;
          3, 4, 5: mode = MODE_DRAIN;
          6, 7:    mode = MODE_NMI;
          8:       mode = MODE_NMI_WIN;
          9:       mode = MODE_PRIO;
          default: mode = MODE_NOISE;
        endcase
        burst = $urandom_range(1, 24);
      end
      repeat (burst) begin
        quiet = counted >= ITEMS - QUIET_TAIL;
        if (!quiet && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 16));
        it = make_request(mode);
        send_request(it);
        if (it.opcode <= OP_PRIO_WRITE && !(it.opcode == OP_EXT_IRQ && !it.info_valid))
          counted++;
      end
    end

    // enter the terminal state by one of its two routes, then confirm it sticks
    if ($urandom_range(0, 1) != 0) begin
      send_request(req(OP_EXT_IRQ, 8'h00, 1, 0, 0, 0, 0, 8'h00));
      while (sb.count < DEPTH) begin
        it            = make_request(MODE_NOISE);
        it.opcode     = OP_EXT_IRQ;
        it.info_valid = 1'b1;
        it.if_flag    = 1'b0;
        send_request(it);
      end
      send_request(req(OP_EXT_IRQ, 8'hFF, 1, 1, 0, 0, 0, 8'h00));
    end else begin
      send_request(req(OP_NMI, 8'h02, 0, 1, 0, 0, 1, 8'h00));
    end
    repeat (20) send_request(make_request(MODE_NOISE));
    send_request(req(OP_NMI, 8'h00, 0, 0, 0, 0, 0, 8'h00));
    send_request(req(OP_PRIO_WRITE, 8'h00, 0, 0, 0, 0, 0, 8'hFF));
    start <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ivq_pkg.sv
hdl/ivq_ring.sv
hdl/ivq_core.sv
hdl/virtual_interrupt_delivery_queue.sv
bench/virtual_interrupt_delivery_queue_test.sv
